>>> design/vrsu_pkg.sv
package vrsu_pkg;

    localparam int SPRITE_MEM_BYTES = 256;
    localparam int PALETTE_BYTES    = 32;
    localparam int OAM_ADDR_W       = $clog2(SPRITE_MEM_BYTES);
    localparam int PAL_ADDR_W       = $clog2(PALETTE_BYTES);

    typedef enum logic [3:0] {
        OP_CPU_READ    = 4'd0,
        OP_CPU_WRITE   = 4'd1,
        OP_COARSE_X    = 4'd2,
        OP_LINE_END    = 4'd3,
        OP_FRAME_COPY  = 4'd4,
        OP_VBLANK_SET  = 4'd5,
        OP_VBLANK_CLR  = 4'd6,
        OP_SPRITE0_HIT = 4'd7,
        OP_OVERFLOW    = 4'd8
    } op_t;

    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam logic [15:0] FINE_Y_MASK   = 16'h7000;
    localparam logic [15:0] COARSE_Y_MASK = 16'h03e0;
    localparam logic [15:0] NT_V_BIT      = 16'h0800;
    localparam logic [15:0] NT_H_BIT      = 16'h0400;
    localparam logic [15:0] HORIZ_MASK    = 16'h041f;
    localparam logic [15:0] HI_ADDR_MASK  = 16'h3f00;
    localparam logic [13:0] PAL_BASE      = 14'h3f00;
    localparam logic [13:0] PAL_FETCH_MSK = 14'h2fff;
    localparam logic [7:0]  OAM_EMPTY     = 8'hff;

    localparam logic [7:0] PAL_INIT [PALETTE_BYTES] = '{
        8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0d,
        8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2c,
        8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
        8'h08, 8'h3a, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2c, 8'h08
    };

    typedef struct packed {
        logic [3:0] opcode;
        logic [2:0] reg_index;
        logic [7:0] write_data;
        logic [7:0] mem_rdata;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        read_valid;
        logic [13:0] mem_addr;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic        nmi_request;
        logic [7:0]  ctrl_byte;
        logic [7:0]  mask_byte;
        logic [2:0]  fine_scroll_x;
        logic [15:0] vram_address;
    } out_item_t;

    typedef struct packed {
        logic                  wr_en;
        logic [OAM_ADDR_W-1:0] wr_addr;
        logic [7:0]            wr_data;
        logic [OAM_ADDR_W-1:0] rd_addr;
    } oam_req_t;

endpackage

>>> design/vrsu_oam.sv
module vrsu_oam (
    input  logic               aclk,
    input  logic               aresetn,
    input  vrsu_pkg::oam_req_t req,
    output logic [7:0]         rd_data
);

    logic [7:0] mem [vrsu_pkg::SPRITE_MEM_BYTES];
    logic [vrsu_pkg::SPRITE_MEM_BYTES-1:0] valid_reg;
    logic [7:0] rd_data_reg;
    logic       rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : vrsu_pkg::OAM_EMPTY;

    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        req.wr_en |-> req.wr_addr != req.rd_addr)
        else $error("oam write and prefetch hit the same entry");

endmodule

>>> design/vrsu_regfile.sv
module vrsu_regfile (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  vrsu_pkg::in_item_t  item,
    input  logic [7:0]          oam_rdata,
    output vrsu_pkg::oam_req_t  oam_req,
    output vrsu_pkg::out_item_t result
);

    logic [15:0] cur_addr_reg, cur_addr_next;
    logic [15:0] tmp_addr_reg, tmp_addr_next;
    logic [2:0]  fine_x_reg, fine_x_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  read_buf_reg, read_buf_next;
    logic [vrsu_pkg::OAM_ADDR_W-1:0] oam_addr_reg, oam_addr_next;
    logic [7:0]  ctrl_reg, ctrl_next;
    logic [7:0]  mask_reg, mask_next;
    logic [4:0]  status_low_reg, status_low_next;
    logic        vblank_reg, vblank_next;
    logic        sprite0_reg, sprite0_next;
    logic        overflow_reg, overflow_next;
    logic [7:0]  pal_reg [vrsu_pkg::PALETTE_BYTES];

    logic        pal_we;
    logic        pal_mirror;
    logic [vrsu_pkg::PAL_ADDR_W-1:0] pal_idx;
    logic [13:0] cpu_addr;
    logic        pal_hit;
    logic [15:0] addr_inc;
    logic        addr_set;
    logic [13:0] maddr;
    logic [15:0] y_stepped;

    function automatic logic [15:0] step_x(input logic [15:0] v);
        logic [15:0] r;
        if (v[4:0] == 5'h1f) begin
            r = {v[15:5], 5'b0} ^ vrsu_pkg::NT_H_BIT;
        end else begin
            r = v + 16'd1;
        end
        return r;
    endfunction

    function automatic logic [15:0] step_y(input logic [15:0] v);
        logic [15:0] r;
        logic [4:0]  row;
        r   = v & ~vrsu_pkg::FINE_Y_MASK;
        row = v[9:5];
        if (v[14:12] != 3'b111) begin
            r = v + 16'h1000;
        end else begin
            if (row == 5'd29) begin
                row = 5'd0;
                r   = r ^ vrsu_pkg::NT_V_BIT;
            end else if (row == 5'd31) begin
                row = 5'd0;
            end else begin
                row = row + 5'd1;
            end
            r = (r & ~vrsu_pkg::COARSE_Y_MASK) | {6'b0, row, 5'b0};
        end
        return r;
    endfunction

    always_comb begin
        cur_addr_next   = cur_addr_reg;
        tmp_addr_next   = tmp_addr_reg;
        fine_x_next     = fine_x_reg;
        toggle_next     = toggle_reg;
        read_buf_next   = read_buf_reg;
        oam_addr_next   = oam_addr_reg;
        ctrl_next       = ctrl_reg;
        mask_next       = mask_reg;
        status_low_next = status_low_reg;
        vblank_next     = vblank_reg;
        sprite0_next    = sprite0_reg;
        overflow_next   = overflow_reg;
        result          = '0;
        oam_req         = '0;
        pal_we          = 1'b0;
        addr_set        = 1'b0;
        maddr           = '0;

        cpu_addr   = cur_addr_reg[13:0];
        pal_hit    = cpu_addr >= vrsu_pkg::PAL_BASE;
        pal_idx    = cpu_addr[vrsu_pkg::PAL_ADDR_W-1:0];
        pal_mirror = pal_idx[3:0] == 4'd0;
        addr_inc   = ctrl_reg[2] ? 16'd32 : 16'd1;
        y_stepped  = step_y(cur_addr_reg);

        if (fire) begin
            case (item.opcode)
                vrsu_pkg::OP_CPU_READ: begin
                    case (item.reg_index)
                        vrsu_pkg::REG_STATUS: begin
                            result.read_data  = {vblank_reg, sprite0_reg, overflow_reg,
                                                 status_low_reg};
                            result.read_valid = 1'b1;
                            vblank_next       = 1'b0;
                            toggle_next       = 1'b0;
                        end
                        vrsu_pkg::REG_OAM_DATA: begin
                            result.read_data  = oam_rdata;
                            result.read_valid = 1'b1;
                        end
                        vrsu_pkg::REG_DATA: begin
                            if (pal_hit) begin
                                result.read_data = pal_reg[pal_idx];
                                maddr            = cpu_addr & vrsu_pkg::PAL_FETCH_MSK;
                            end else begin
                                result.read_data = read_buf_reg;
                                maddr            = cpu_addr;
                            end
                            result.read_valid = 1'b1;
                            read_buf_next     = item.mem_rdata;
                            addr_set          = 1'b1;
                            cur_addr_next     = cur_addr_reg + addr_inc;
                        end
                        default: begin
                        end
                    endcase
                end
                vrsu_pkg::OP_CPU_WRITE: begin
                    case (item.reg_index)
                        vrsu_pkg::REG_CTRL: begin
                            ctrl_next     = item.write_data;
                            tmp_addr_next = {tmp_addr_reg[15:12], item.write_data[1:0],
                                             tmp_addr_reg[9:0]};
                        end
                        vrsu_pkg::REG_MASK: begin
                            mask_next = item.write_data;
                        end
                        vrsu_pkg::REG_STATUS: begin
                            status_low_next = item.write_data[4:0];
                        end
                        vrsu_pkg::REG_OAM_ADDR: begin
                            oam_addr_next = item.write_data;
                        end
                        vrsu_pkg::REG_OAM_DATA: begin
                            oam_req.wr_en   = 1'b1;
                            oam_req.wr_addr = oam_addr_reg;
                            oam_req.wr_data = item.write_data;
                            oam_addr_next   = oam_addr_reg + 1'b1;
                        end
                        vrsu_pkg::REG_SCROLL: begin
                            if (toggle_reg) begin
                                tmp_addr_next = {1'b0, item.write_data[2:0],
                                                 tmp_addr_reg[11:10],
                                                 item.write_data[7:3],
                                                 tmp_addr_reg[4:0]};
                                toggle_next   = 1'b0;
                            end else begin
                                tmp_addr_next = {tmp_addr_reg[15:5], item.write_data[7:3]};
                                fine_x_next   = item.write_data[2:0];
                                toggle_next   = 1'b1;
                            end
                        end
                        vrsu_pkg::REG_ADDR: begin
                            if (toggle_reg) begin
                                tmp_addr_next = {tmp_addr_reg[15:8], item.write_data};
                                cur_addr_next = {tmp_addr_reg[15:8], item.write_data};
                                toggle_next   = 1'b0;
                            end else begin
                                tmp_addr_next = {2'b0, item.write_data[5:0],
                                                 tmp_addr_reg[7:0]};
                                toggle_next   = 1'b1;
                            end
                        end
                        default: begin
                            if (pal_hit) begin
                                pal_we = 1'b1;
                            end else begin
                                result.mem_write = 1'b1;
                                result.mem_wdata = item.write_data;
                                maddr            = cpu_addr;
                                addr_set         = 1'b1;
                            end
                            cur_addr_next = cur_addr_reg + addr_inc;
                        end
                    endcase
                end
                vrsu_pkg::OP_COARSE_X: begin
                    if (mask_reg[3]) begin
                        cur_addr_next = step_x(cur_addr_reg);
                    end
                end
                vrsu_pkg::OP_LINE_END: begin
                    if (mask_reg[3]) begin
                        cur_addr_next = (y_stepped & ~vrsu_pkg::HORIZ_MASK)
                                      | (tmp_addr_reg & vrsu_pkg::HORIZ_MASK);
                    end
                end
                vrsu_pkg::OP_FRAME_COPY: begin
                    if (mask_reg[3]) begin
                        cur_addr_next = (cur_addr_reg & vrsu_pkg::HORIZ_MASK)
                                      | (tmp_addr_reg & ~vrsu_pkg::HORIZ_MASK);
                    end
                end
                vrsu_pkg::OP_VBLANK_SET: begin
                    vblank_next = 1'b1;
                end
                vrsu_pkg::OP_VBLANK_CLR: begin
                    vblank_next   = 1'b0;
                    sprite0_next  = 1'b0;
                    overflow_next = 1'b0;
                end
                vrsu_pkg::OP_SPRITE0_HIT: begin
                    sprite0_next = 1'b1;
                end
                vrsu_pkg::OP_OVERFLOW: begin
                    overflow_next = 1'b1;
                end
                default: begin
                end
            endcase
        end

        oam_req.rd_addr      = oam_addr_next;
        result.mem_addr      = addr_set ? maddr : cur_addr_next[13:0];
        result.nmi_request   = vblank_next & ctrl_next[7];
        result.ctrl_byte     = ctrl_next;
        result.mask_byte     = mask_next;
        result.fine_scroll_x = fine_x_next;
        result.vram_address  = cur_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_addr_reg   <= '0;
            tmp_addr_reg   <= '0;
            fine_x_reg     <= '0;
            toggle_reg     <= 1'b0;
            read_buf_reg   <= '0;
            oam_addr_reg   <= '0;
            ctrl_reg       <= '0;
            mask_reg       <= '0;
            status_low_reg <= '0;
            vblank_reg     <= 1'b0;
            sprite0_reg    <= 1'b0;
            overflow_reg   <= 1'b0;
            pal_reg        <= vrsu_pkg::PAL_INIT;
        end else begin
            cur_addr_reg   <= cur_addr_next;
            tmp_addr_reg   <= tmp_addr_next;
            fine_x_reg     <= fine_x_next;
            toggle_reg     <= toggle_next;
            read_buf_reg   <= read_buf_next;
            oam_addr_reg   <= oam_addr_next;
            ctrl_reg       <= ctrl_next;
            mask_reg       <= mask_next;
            status_low_reg <= status_low_next;
            vblank_reg     <= vblank_next;
            sprite0_reg    <= sprite0_next;
            overflow_reg   <= overflow_next;
            if (pal_we) begin
                pal_reg[pal_idx] <= item.write_data;
                if (pal_mirror) begin
                    pal_reg[pal_idx ^ 5'h10] <= item.write_data;
                end
            end
        end
    end

    a_status_clears_toggle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.opcode == vrsu_pkg::OP_CPU_READ && item.reg_index == vrsu_pkg::REG_STATUS
        |=> !toggle_reg && !vblank_reg)
        else $error("status read left toggle or vblank set");

    a_addr_load: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && toggle_reg && item.opcode == vrsu_pkg::OP_CPU_WRITE
        && item.reg_index == vrsu_pkg::REG_ADDR
        |=> cur_addr_reg == tmp_addr_reg)
        else $error("second address write did not load current address");

endmodule

>>> design/video_register_and_scroll_unit.sv
// Channel  Direction  Handshake           Payload
// s_       in         s_valid / s_ready   s_item  (vrsu_pkg::in_item_t)
// m_       out        m_valid / m_ready   m_item  (vrsu_pkg::out_item_t)
//
// One item per cycle sustained while m_ready stays high; an item's result reaches m_ through
// the input register, then the result register, with all state updated in between.
// Sprite memory reads come from a registered port addressed with the next sprite address.
// Reset is synchronous: state cleared, palette loaded with its initial table,
// sprite memory entries marked empty so they read 0xff until written.
// With m_ready low the result holds and one more item waits in the input register.
module video_register_and_scroll_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  vrsu_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output vrsu_pkg::out_item_t m_item
);

    logic                in_valid_reg, in_valid_next;
    vrsu_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    vrsu_pkg::out_item_t out_item_reg;
    vrsu_pkg::out_item_t result;
    vrsu_pkg::oam_req_t  oam_req;
    logic [7:0]          oam_rdata;
    logic                fire;
    logic                accept;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= s_item;
        end
        if (fire) begin
            out_item_reg <= result;
        end
    end

    vrsu_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_item_reg),
        .oam_rdata (oam_rdata),
        .oam_req   (oam_req),
        .result    (result)
    );

    vrsu_oam u_oam (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (oam_req),
        .rd_data (oam_rdata)
    );

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    a_fire_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule

>>> bench/tb.sv
module tb;
    import vrsu_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_LIMIT   = 2000;
    localparam int N_DIRECTED   = 27;

    localparam logic [7:0] BOOT_PALETTE [32] = '{
        8'h09, 8'h01, 8'h00, 8'h01, 8'h00, 8'h02, 8'h02, 8'h0d,
        8'h08, 8'h10, 8'h08, 8'h24, 8'h00, 8'h00, 8'h04, 8'h2c,
        8'h09, 8'h01, 8'h34, 8'h03, 8'h00, 8'h04, 8'h00, 8'h14,
        8'h08, 8'h3a, 8'h00, 8'h02, 8'h00, 8'h20, 8'h2c, 8'h08
    };

    typedef struct {
        in_item_t   item;
        bit         known;
        logic       known_valid;
        logic [7:0] known_byte;
    } bus_event_row_t;

    bus_event_row_t directed_rows [N_DIRECTED] = '{
        '{'{OP_CPU_READ,    REG_STATUS,   8'h00, 8'h00}, 1'b1, 1'b1, 8'h00},
        '{'{OP_CPU_READ,    REG_OAM_DATA, 8'h00, 8'h00}, 1'b1, 1'b1, 8'hff},
        '{'{OP_CPU_READ,    REG_DATA,     8'h00, 8'ha5}, 1'b1, 1'b1, 8'h00},
        '{'{OP_CPU_READ,    REG_CTRL,     8'h00, 8'h00}, 1'b1, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_CTRL,     8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_MASK,     8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_STATUS,   8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_VBLANK_SET,  REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_SPRITE0_HIT, REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_OVERFLOW,    REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_READ,    REG_STATUS,   8'h00, 8'h00}, 1'b1, 1'b1, 8'hff},
        '{'{OP_VBLANK_CLR,  REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_OAM_ADDR, 8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_OAM_DATA, 8'h5a, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_READ,    REG_OAM_DATA, 8'h00, 8'h00}, 1'b1, 1'b1, 8'hff},
        '{'{OP_CPU_WRITE,   REG_SCROLL,   8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_SCROLL,   8'hff, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h3f, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h10, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_DATA,     8'h2a, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h3f, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_WRITE,   REG_ADDR,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_CPU_READ,    REG_DATA,     8'h00, 8'h77}, 1'b1, 1'b1, 8'h2a},
        '{'{OP_COARSE_X,    REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_LINE_END,    REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{OP_FRAME_COPY,  REG_CTRL,     8'h00, 8'h00}, 1'b0, 1'b0, 8'h00},
        '{'{4'hf,           REG_DATA,     8'hff, 8'hff}, 1'b0, 1'b0, 8'h00}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    video_register_and_scroll_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [15:0] scroll_v;
    logic [15:0] scroll_t;
    logic [2:0]  scroll_fine_x;
    logic        latch_second;
    logic [7:0]  data_buffer;
    logic [7:0]  oam_ptr;
    logic [7:0]  oam_shadow [256];
    logic [7:0]  palette_shadow [32];
    logic [7:0]  ctrl_q;
    logic [7:0]  mask_q;
    logic [4:0]  status_low_q;
    logic        vblank_q;
    logic        hit_q;
    logic        ovf_q;

    out_item_t predicted_outputs [$];

    int fail_count;
    int n_items;
    int n_checked;
    int n_vram_writes;
    int n_palette_writes;
    int n_row_wraps;
    int idle_cycles;
    bit src_steady;
    bit sink_steady;

    function automatic out_item_t advance_register_unit(in_item_t it);
        out_item_t   r;
        logic [13:0] a14;
        logic [15:0] v;
        logic [4:0]  row;
        logic        addr_taken;
        r = '0;
        addr_taken = 1'b0;
        a14 = scroll_v[13:0];
        case (it.opcode)
            OP_CPU_READ: begin
                case (it.reg_index)
                    REG_STATUS: begin
                        r.read_data = {vblank_q, hit_q, ovf_q, status_low_q};
                        r.read_valid = 1'b1;
                        vblank_q = 1'b0;
                        latch_second = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        r.read_data = oam_shadow[oam_ptr];
                        r.read_valid = 1'b1;
                    end
                    REG_DATA: begin
                        if (a14 < PAL_BASE) begin
                            r.read_data = data_buffer;
                            r.mem_addr = a14;
                        end else begin
                            r.read_data = palette_shadow[a14[4:0]];
                            r.mem_addr = a14 & PAL_FETCH_MSK;
                        end
                        r.read_valid = 1'b1;
                        addr_taken = 1'b1;
                        data_buffer = it.mem_rdata;
                        scroll_v = scroll_v + (ctrl_q[2] ? 16'd32 : 16'd1);
                    end
                    default: ;
                endcase
            end
            OP_CPU_WRITE: begin
                case (it.reg_index)
                    REG_CTRL: begin
                        ctrl_q = it.write_data;
                        scroll_t[11:10] = it.write_data[1:0];
                    end
                    REG_MASK: mask_q = it.write_data;
                    REG_STATUS: status_low_q = it.write_data[4:0];
                    REG_OAM_ADDR: oam_ptr = it.write_data;
                    REG_OAM_DATA: begin
                        oam_shadow[oam_ptr] = it.write_data;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (latch_second) begin
                            scroll_t = (scroll_t & 16'h0c1f)
                                     | (16'(it.write_data[2:0]) << 12)
                                     | (16'(it.write_data[7:3]) << 5);
                            latch_second = 1'b0;
                        end else begin
                            scroll_t[4:0] = it.write_data[7:3];
                            scroll_fine_x = it.write_data[2:0];
                            latch_second = 1'b1;
                        end
                    end
                    REG_ADDR: begin
                        if (latch_second) begin
                            scroll_t[7:0] = it.write_data;
                            scroll_v = scroll_t;
                            latch_second = 1'b0;
                        end else begin
                            scroll_t = {2'b00, it.write_data[5:0], scroll_t[7:0]};
                            latch_second = 1'b1;
                        end
                    end
                    default: begin
                        if (a14 < PAL_BASE) begin
                            r.mem_write = 1'b1;
                            r.mem_wdata = it.write_data;
                            r.mem_addr = a14;
                            addr_taken = 1'b1;
                            n_vram_writes++;
                        end else begin
                            palette_shadow[a14[4:0]] = it.write_data;
                            if (a14[4:0] == 5'h10) palette_shadow[0] = it.write_data;
                            else if (a14[4:0] == 5'h00) palette_shadow[16] = it.write_data;
                            n_palette_writes++;
                        end
                        scroll_v = scroll_v + (ctrl_q[2] ? 16'd32 : 16'd1);
                    end
                endcase
            end
            OP_COARSE_X: begin
                if (mask_q[3]) begin
                    if (scroll_v[4:0] == 5'h1f) scroll_v = {scroll_v[15:5], 5'h00} ^ NT_H_BIT;
                    else scroll_v = scroll_v + 16'd1;
                end
            end
            OP_LINE_END: begin
                if (mask_q[3]) begin
                    v = scroll_v;
                    if ((v & FINE_Y_MASK) != FINE_Y_MASK) begin
                        v = v + 16'h1000;
                    end else begin
                        v = v & ~FINE_Y_MASK;
                        row = v[9:5];
                        if (row == 5'd29) begin
                            row = 5'd0;
                            v = v ^ NT_V_BIT;
                            n_row_wraps++;
                        end else if (row == 5'd31) begin
                            row = 5'd0;
                        end else begin
                            row = row + 5'd1;
                        end
                        v[9:5] = row;
                    end
                    scroll_v = (v & ~HORIZ_MASK) | (scroll_t & HORIZ_MASK);
                end
            end
            OP_FRAME_COPY: begin
                if (mask_q[3]) scroll_v = (scroll_v & HORIZ_MASK) | (scroll_t & ~HORIZ_MASK);
            end
            OP_VBLANK_SET: vblank_q = 1'b1;
            OP_VBLANK_CLR: begin
                vblank_q = 1'b0;
                hit_q = 1'b0;
                ovf_q = 1'b0;
            end
            OP_SPRITE0_HIT: hit_q = 1'b1;
            OP_OVERFLOW: ovf_q = 1'b1;
            default: ;
        endcase
        if (!addr_taken) r.mem_addr = scroll_v[13:0];
        r.nmi_request = vblank_q & ctrl_q[7];
        r.ctrl_byte = ctrl_q;
        r.mask_byte = mask_q;
        r.fine_scroll_x = scroll_fine_x;
        r.vram_address = scroll_v;
        return r;
    endfunction

    function automatic in_item_t random_bus_event();
        in_item_t it;
        int       sel;
        int       pick;
        it.write_data = 8'($urandom);
        it.mem_rdata = 8'($urandom);
        it.reg_index = 3'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
            it.opcode = OP_CPU_WRITE;
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1: it.reg_index = REG_ADDR;
                2, 3: it.reg_index = REG_SCROLL;
                4: it.reg_index = REG_DATA;
                5: it.reg_index = REG_CTRL;
                6: it.reg_index = REG_MASK;
                7: it.reg_index = REG_STATUS;
                8: it.reg_index = REG_OAM_ADDR;
                default: it.reg_index = REG_OAM_DATA;
            endcase
            // steer address writes into the palette window now and then
            if (it.reg_index == REG_ADDR && $urandom_range(0, 3) == 0)
                it.write_data[5:0] = 6'h3f;
            if (it.reg_index == REG_MASK && $urandom_range(0, 3) != 0)
                it.write_data[3] = 1'b1;
        end else if (sel < 65) begin
            it.opcode = OP_CPU_READ;
            pick = $urandom_range(0, 5);
            if (pick < 2) it.reg_index = REG_DATA;
            else if (pick == 2) it.reg_index = REG_STATUS;
            else if (pick == 3) it.reg_index = REG_OAM_DATA;
        end else if (sel < 85) begin
            it.opcode = 4'($urandom_range(OP_COARSE_X, OP_FRAME_COPY));
        end else if (sel < 97) begin
            it.opcode = 4'($urandom_range(OP_VBLANK_SET, OP_OVERFLOW));
        end else begin
            it.opcode = 4'($urandom_range(9, 15));
        end
        return it;
    endfunction

    task automatic issue_bus_event(in_item_t it, bit known, logic known_valid,
                                   logic [7:0] known_byte);
        int        gap;
        out_item_t exp;
        if ($urandom_range(0, 99) == 0) src_steady = !src_steady;
        gap = src_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp = advance_register_unit(it);
        if (known) begin
            exp.read_valid = known_valid;
            exp.read_data = known_byte;
        end
        predicted_outputs.push_back(exp);
        n_items++;
    endtask

    task automatic report_mismatch(string field, int unsigned exp_v, int unsigned got_v);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch on item %0d, %s: expected 0x%0h, got 0x%0h",
                     n_checked, field, exp_v, got_v);
    endtask

    task automatic check_register_output(out_item_t got);
        out_item_t exp;
        if (predicted_outputs.size() == 0) begin
            fail_count++;
            if (fail_count <= 10) $display("unexpected item on result channel: %h", got);
            return;
        end
        exp = predicted_outputs.pop_front();
        if (got.read_data !== exp.read_data)
            report_mismatch("read_data", exp.read_data, got.read_data);
        if (got.read_valid !== exp.read_valid)
            report_mismatch("read_valid", exp.read_valid, got.read_valid);
        if (got.mem_addr !== exp.mem_addr)
            report_mismatch("mem_addr", exp.mem_addr, got.mem_addr);
        if (got.mem_write !== exp.mem_write)
            report_mismatch("mem_write", exp.mem_write, got.mem_write);
        if (got.mem_wdata !== exp.mem_wdata)
            report_mismatch("mem_wdata", exp.mem_wdata, got.mem_wdata);
        if (got.nmi_request !== exp.nmi_request)
            report_mismatch("nmi_request", exp.nmi_request, got.nmi_request);
        if (got.ctrl_byte !== exp.ctrl_byte)
            report_mismatch("ctrl_byte", exp.ctrl_byte, got.ctrl_byte);
        if (got.mask_byte !== exp.mask_byte)
            report_mismatch("mask_byte", exp.mask_byte, got.mask_byte);
        if (got.fine_scroll_x !== exp.fine_scroll_x)
            report_mismatch("fine_scroll_x", exp.fine_scroll_x, got.fine_scroll_x);
        if (got.vram_address !== exp.vram_address)
            report_mismatch("vram_address", exp.vram_address, got.vram_address);
        n_checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("video_register_and_scroll_unit test failed");
                $finish;
            end
        end
    end

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            if ($urandom_range(0, 99) == 0) sink_steady = !sink_steady;
            gap = sink_steady ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            check_register_output(m_item);
        end
    end

    initial begin
        in_item_t it;
        int       n_effective;
        scroll_v = '0;
        scroll_t = '0;
        scroll_fine_x = '0;
        latch_second = 1'b0;
        data_buffer = '0;
        oam_ptr = '0;
        ctrl_q = '0;
        mask_q = '0;
        status_low_q = '0;
        vblank_q = 1'b0;
        hit_q = 1'b0;
        ovf_q = 1'b0;
        for (int i = 0; i < 256; i++) oam_shadow[i] = OAM_EMPTY;
        for (int i = 0; i < 32; i++) palette_shadow[i] = BOOT_PALETTE[i];
        fail_count = 0;
        n_items = 0;
        n_checked = 0;
        n_vram_writes = 0;
        n_palette_writes = 0;
        n_row_wraps = 0;
        idle_cycles = 0;
        n_effective = 0;
        src_steady = 1'b0;
        sink_steady = 1'b0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            issue_bus_event(directed_rows[i].item, directed_rows[i].known,
                            directed_rows[i].known_valid, directed_rows[i].known_byte);

        while (n_effective < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                // render a stretch of scanline: column steps with line ends
                repeat (32) begin
                    it = '0;
                    it.write_data = 8'($urandom);
                    it.mem_rdata = 8'($urandom);
                    it.reg_index = 3'($urandom);
                    it.opcode = $urandom_range(0, 1) ? OP_COARSE_X : OP_LINE_END;
                    issue_bus_event(it, 1'b0, 1'b0, 8'h00);
                end
                n_effective += 32;
            end else begin
                it = random_bus_event();
                issue_bus_event(it, 1'b0, 1'b0, 8'h00);
                if (it.opcode <= OP_OVERFLOW) n_effective++;
            end
        end
        s_valid <= 1'b0;

        while (predicted_outputs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d items driven, %0d results compared field by field",
                 n_items, n_checked);
        $display("vram writes %0d, palette writes %0d, coarse row wraps at 29: %0d",
                 n_vram_writes, n_palette_writes, n_row_wraps);
        if (fail_count == 0) begin
            $display("video_register_and_scroll_unit test passed");
        end else begin
            $display("%0d failures", fail_count);
            $display("video_register_and_scroll_unit test failed");
        end
        $finish;
    end
endmodule
